/* hw/rtl/tcpop_pkg.sv */
// ----------------------------------------------------------------------------
// TCP header option parser package
// Shared payload types, item kinds, error codes and option kinds.
// ----------------------------------------------------------------------------
package tcpop_pkg;

   // Input transaction: one raw segment byte.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // Output transaction: one decoded item.
   typedef struct packed {
      logic [4:0]  item_kind;
      logic [63:0] item_value;
      logic [2:0]  error_code;
      logic        last_of_run;
      logic        segment_end;
   } rsp_type;

   // Up to two items produced by one byte, in delivery order.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } rsp_pair_type;

   // Item kinds.
   localparam logic [4:0] KIND_PORTS     = 5'd0;
   localparam logic [4:0] KIND_SEQ       = 5'd1;
   localparam logic [4:0] KIND_ACK       = 5'd2;
   localparam logic [4:0] KIND_OFFSET    = 5'd3;
   localparam logic [4:0] KIND_WINDOW    = 5'd4;
   localparam logic [4:0] KIND_CHECKSUM  = 5'd5;
   localparam logic [4:0] KIND_URGENT    = 5'd6;
   localparam logic [4:0] KIND_OPT_END   = 5'd7;
   localparam logic [4:0] KIND_OPT_NOP   = 5'd8;
   localparam logic [4:0] KIND_OPT_MSS   = 5'd9;
   localparam logic [4:0] KIND_OPT_WS    = 5'd10;
   localparam logic [4:0] KIND_OPT_SOK   = 5'd11;
   localparam logic [4:0] KIND_OPT_SACK  = 5'd12;
   localparam logic [4:0] KIND_OPT_TS    = 5'd13;
   localparam logic [4:0] KIND_OPT_TFO   = 5'd14;
   localparam logic [4:0] KIND_OPT_UNK   = 5'd15;
   localparam logic [4:0] KIND_DONE      = 5'd16;
   localparam logic [4:0] KIND_ERROR     = 5'd17;

   // Error codes.
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_SHORT      = 3'd1;
   localparam logic [2:0] ERR_OFFSET     = 3'd2;
   localparam logic [2:0] ERR_TRUNCATED  = 3'd3;
   localparam logic [2:0] ERR_OPTION     = 3'd4;

   // TCP option kinds.
   localparam logic [7:0] OPT_END        = 8'd0;
   localparam logic [7:0] OPT_NOP        = 8'd1;
   localparam logic [7:0] OPT_MSS        = 8'd2;
   localparam logic [7:0] OPT_WSCALE     = 8'd3;
   localparam logic [7:0] OPT_SACK_OK    = 8'd4;
   localparam logic [7:0] OPT_SACK       = 8'd5;
   localparam logic [7:0] OPT_TSTAMP     = 8'd8;
   localparam logic [7:0] OPT_TFO        = 8'd34;

   // Fixed header size in bytes and the minimum legal data offset.
   localparam int unsigned MIN_HDR_BYTES = 20;
   localparam logic [3:0]  MIN_HDR_WORDS = 4'd5;

endpackage

/* hw/rtl/tcpop_parser.sv */
// ----------------------------------------------------------------------------
// TCP header option parser step
// Input register, parser state and the per-byte decode into up to two items.
// ----------------------------------------------------------------------------
module tcpop_parser import tcpop_pkg::*; #(
   parameter int LENGTH_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   input  logic         buf_free,
   output logic         advance,
   output rsp_pair_type pair
);

   localparam logic [LENGTH_BITS-1:0] POS_MAX = {LENGTH_BITS{1'b1}};

   logic                   in_valid_ff, in_valid_in;
   req_type                in_req_ff;

   logic [LENGTH_BITS-1:0] pos_ff, pos_in;
   logic [3:0]             hw_ff, hw_in;
   logic [63:0]            acc_ff, acc_in;
   logic [5:0]             rem_ff, rem_in;
   logic [7:0]             okind_ff, okind_in;
   logic [7:0]             olen_ff, olen_in;
   logic [7:0]             oidx_ff, oidx_in;
   logic                   fault_ff, fault_in;
   logic                   stop_ff, stop_in;

   logic [7:0]             b;
   logic                   last;
   logic [LENGTH_BITS-1:0] pos_sat;
   logic [5:0]             hdr_bytes;
   logic                   too_short;
   logic                   opt_ok;
   logic                   opt_done_chk;
   logic [7:0]             sack_span;
   logic [7:0]             rem_ext;
   rsp_type                item_a, item_b;
   logic                   a_valid;

   assign req_ready = !in_valid_ff || buf_free;
   assign advance   = in_valid_ff && buf_free;
   assign b         = in_req_ff.data_byte;
   assign last      = in_req_ff.last_byte;
   assign pos_sat   = (pos_ff != POS_MAX) ? pos_ff + 1'b1 : POS_MAX;
   assign hdr_bytes = {hw_ff, 2'b00};
   assign rem_ext   = {2'b00, rem_ff};
   assign sack_span = (olen_ff - 8'd2) & 8'hF8;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      hw_in        = hw_ff;
      acc_in       = {acc_ff[55:0], b};
      rem_in       = rem_ff;
      okind_in     = okind_ff;
      olen_in      = olen_ff;
      oidx_in      = oidx_ff;
      fault_in     = fault_ff;
      stop_in      = stop_ff;
      a_valid      = 1'b0;
      item_a       = '0;
      item_b       = '0;
      too_short    = 1'b0;
      opt_ok       = 1'b1;
      opt_done_chk = 1'b0;

      if (pos_ff < LENGTH_BITS'(MIN_HDR_BYTES)) begin
         unique case (pos_ff[4:0])
            5'd3: begin
               a_valid = 1'b1;
               item_a.item_kind  = KIND_PORTS;
               item_a.item_value = {32'd0, acc_in[31:0]};
            end
            5'd7: begin
               a_valid = 1'b1;
               item_a.item_kind  = KIND_SEQ;
               item_a.item_value = {32'd0, acc_in[31:0]};
            end
            5'd11: begin
               a_valid = 1'b1;
               item_a.item_kind  = KIND_ACK;
               item_a.item_value = {32'd0, acc_in[31:0]};
            end
            5'd12: begin
               hw_in  = b[7:4];
               rem_in = (b[7:4] > MIN_HDR_WORDS) ?
                        {b[7:4] - MIN_HDR_WORDS, 2'b00} : 6'd0;
            end
            5'd13: begin
               a_valid = 1'b1;
               item_a.item_kind  = KIND_OFFSET;
               item_a.item_value = {51'd0, hw_ff, acc_in[8], b};
            end
            5'd15: begin
               a_valid = 1'b1;
               item_a.item_kind  = KIND_WINDOW;
               item_a.item_value = {48'd0, acc_in[15:0]};
            end
            5'd17: begin
               a_valid = 1'b1;
               item_a.item_kind  = KIND_CHECKSUM;
               item_a.item_value = {48'd0, acc_in[15:0]};
            end
            5'd19: begin
               a_valid = 1'b1;
               item_a.item_kind  = KIND_URGENT;
               item_a.item_value = {48'd0, acc_in[15:0]};
            end
            default: begin
            end
         endcase
      end else if (!stop_ff && rem_ff != 6'd0) begin
         if (oidx_ff == 8'd0) begin
            // Kind byte of a new option.
            okind_in = b;
            too_short = ((b == OPT_MSS) && (rem_ff < 6'd4)) ||
                        ((b == OPT_WSCALE) && (rem_ff < 6'd3)) ||
                        ((b == OPT_TSTAMP) && (rem_ff < 6'd10)) ||
                        (rem_ff < 6'd2);
            if (b == OPT_END) begin
               a_valid = 1'b1;
               item_a.item_kind = KIND_OPT_END;
               stop_in = 1'b1;
            end else if (b == OPT_NOP) begin
               a_valid = 1'b1;
               item_a.item_kind = KIND_OPT_NOP;
               rem_in = rem_ff - 6'd1;
               if (rem_ff == 6'd1) begin
                  stop_in = 1'b1;
               end
            end else if (too_short) begin
               fault_in = 1'b1;
               stop_in  = 1'b1;
            end else begin
               oidx_in = 8'd1;
            end
         end else begin
            if (oidx_ff == 8'd1) begin
               // Length byte: check it against the kind and the bytes left.
               olen_in = b;
               unique case (okind_ff)
                  OPT_MSS:     opt_ok = (b == 8'd4);
                  OPT_WSCALE:  opt_ok = (b == 8'd3);
                  OPT_SACK_OK: opt_ok = (b == 8'd2);
                  OPT_SACK:    opt_ok = (b >= 8'd10) && (b <= rem_ext);
                  OPT_TSTAMP:  opt_ok = (b == 8'd10);
                  OPT_TFO:     opt_ok = (b >= 8'd6) && (b <= 8'd18) && (b <= rem_ext);
                  default:     opt_ok = (b >= 8'd2) && (b <= rem_ext);
               endcase
               if (!opt_ok) begin
                  fault_in = 1'b1;
                  stop_in  = 1'b1;
               end else begin
                  opt_done_chk = 1'b1;
                  if (okind_ff == OPT_SACK_OK) begin
                     a_valid = 1'b1;
                     item_a.item_kind = KIND_OPT_SOK;
                  end else if (okind_ff != OPT_MSS && okind_ff != OPT_WSCALE &&
                               okind_ff != OPT_SACK && okind_ff != OPT_TSTAMP &&
                               okind_ff != OPT_TFO) begin
                     a_valid = 1'b1;
                     item_a.item_kind  = KIND_OPT_UNK;
                     item_a.item_value = {48'd0, okind_ff, b};
                  end
               end
            end else begin
               // Body bytes of an accepted option.
               opt_done_chk = 1'b1;
               unique case (okind_ff)
                  OPT_MSS: begin
                     if (oidx_ff == 8'd3) begin
                        a_valid = 1'b1;
                        item_a.item_kind  = KIND_OPT_MSS;
                        item_a.item_value = {48'd0, acc_in[15:0]};
                     end
                  end
                  OPT_WSCALE: begin
                     if (oidx_ff == 8'd2) begin
                        a_valid = 1'b1;
                        item_a.item_kind  = KIND_OPT_WS;
                        item_a.item_value = {56'd0, b};
                     end
                  end
                  OPT_SACK: begin
                     // A block completes every eight bytes; a partial tail is skipped.
                     if (oidx_ff[2:0] == 3'd1 &&
                         {1'b0, oidx_ff} <= {1'b0, sack_span} + 9'd1) begin
                        a_valid = 1'b1;
                        item_a.item_kind  = KIND_OPT_SACK;
                        item_a.item_value = acc_in;
                     end
                  end
                  OPT_TSTAMP: begin
                     if (oidx_ff == 8'd9) begin
                        a_valid = 1'b1;
                        item_a.item_kind  = KIND_OPT_TS;
                        item_a.item_value = acc_in;
                     end
                  end
                  OPT_TFO: begin
                     a_valid = 1'b1;
                     item_a.item_kind  = KIND_OPT_TFO;
                     item_a.item_value = {48'd0, oidx_ff - 8'd2, b};
                  end
                  default: begin
                  end
               endcase
            end
            if (opt_done_chk) begin
               if ({1'b0, oidx_ff} + 9'd1 == {1'b0, olen_in}) begin
                  rem_in  = rem_ff - olen_in[5:0];
                  oidx_in = 8'd0;
                  if (rem_ext == olen_in) begin
                     stop_in = 1'b1;
                  end
               end else begin
                  oidx_in = oidx_ff + 8'd1;
               end
            end
         end
      end

      if (last) begin
         item_b.segment_end = 1'b1;
         item_b.last_of_run = 1'b1;
         item_b.item_kind   = KIND_ERROR;
         if (pos_sat < LENGTH_BITS'(MIN_HDR_BYTES)) begin
            item_b.error_code = ERR_SHORT;
         end else if (hw_ff < MIN_HDR_WORDS) begin
            item_b.error_code = ERR_OFFSET;
         end else if (pos_sat < LENGTH_BITS'(hdr_bytes)) begin
            item_b.error_code = ERR_TRUNCATED;
         end else if (fault_ff || fault_in) begin
            item_b.error_code = ERR_OPTION;
         end else begin
            item_b.item_kind  = KIND_DONE;
            item_b.item_value = 64'(pos_sat - LENGTH_BITS'(hdr_bytes));
         end
         pos_in   = '0;
         hw_in    = '0;
         acc_in   = '0;
         rem_in   = '0;
         okind_in = '0;
         olen_in  = '0;
         oidx_in  = '0;
         fault_in = 1'b0;
         stop_in  = 1'b0;
      end else begin
         pos_in = pos_sat;
      end

      item_a.last_of_run = !last;
      pair = '0;
      if (a_valid) begin
         pair.first  = item_a;
         pair.second = item_b;
         pair.count  = last ? 2'd2 : 2'd1;
      end else begin
         pair.first  = item_b;
         pair.count  = last ? 2'd1 : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pos_ff      <= '0;
         hw_ff       <= '0;
         acc_ff      <= '0;
         rem_ff      <= '0;
         okind_ff    <= '0;
         olen_ff     <= '0;
         oidx_ff     <= '0;
         fault_ff    <= 1'b0;
         stop_ff     <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            pos_ff   <= pos_in;
            hw_ff    <= hw_in;
            acc_ff   <= acc_in;
            rem_ff   <= rem_in;
            okind_ff <= okind_in;
            olen_ff  <= olen_in;
            oidx_ff  <= oidx_in;
            fault_ff <= fault_in;
            stop_ff  <= stop_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_req_ff <= req_data;
      end
   end

endmodule

/* hw/rtl/tcpop_result_buf.sv */
// ----------------------------------------------------------------------------
// TCP header option parser result buffer
// Two-entry result register that delivers the items of one byte in order.
// ----------------------------------------------------------------------------
module tcpop_result_buf import tcpop_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_pair_type pair,
   output logic         buf_free,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   logic [1:0] count_ff, count_in;
   rsp_type    slot0_ff, slot0_in;
   rsp_type    slot1_ff, slot1_in;

   // The buffer can take a new pair when it will be empty after this cycle.
   assign buf_free  = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp_ready);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot0_ff;

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (load) begin
         count_in = pair.count;
         slot0_in = pair.first;
         slot1_in = pair.second;
      end else if (rsp_valid && rsp_ready) begin
         count_in = count_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

/* hw/rtl/tcp_header_option_parser_unit.sv */
// ----------------------------------------------------------------------------
// TCP header option parser unit
// Decodes a TCP segment byte by byte into header, option and closing items.
// ----------------------------------------------------------------------------
// Path: an accepted byte waits in the input register and is decoded into the result
// buffer when that buffer will be empty; its first item is then offered from there.
// Throughput: one byte per cycle while the receiver takes every item; a byte that
// yields two items (the final byte when it also yields a field or option item) holds
// the result register until both are taken, so the following byte waits.
// Reset: synchronous and active high; clears all parser state and both buffers.
// ----------------------------------------------------------------------------
module tcp_header_option_parser_unit import tcpop_pkg::*; #(
   parameter int LENGTH_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // The byte transaction is captured in an input register. When the result
   // buffer will be empty after the current cycle, the registered byte runs
   // through the parser logic, which updates the parser state (byte count,
   // data offset, field accumulator and option walker) and loads zero, one
   // or two items into the result buffer.
   rsp_pair_type pair;
   logic         buf_free;
   logic         advance;

   tcpop_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .buf_free  (buf_free),
      .advance   (advance),
      .pair      (pair)
   );

   // The result buffer delivers one item per cycle of rsp_ready, oldest first.
   tcpop_result_buf u_result_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .pair      (pair),
      .buf_free  (buf_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* sim/tb_tcp_header_option_parser_unit.sv */
// ----------------------------------------------------------------------------
// Testbench for the TCP header option parser unit
// Streams TCP segments into the parser one byte per transaction and checks
// every decoded item against a cycle-free prediction of the parser. Segments
// range from clean headers with well-formed option lists to short, cut,
// low-offset, noisy and broken-option segments. Both handshakes idle at
// random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_tcp_header_option_parser_unit;
   import tcpop_pkg::*;

   localparam int CLK_PERIOD = 8;
   localparam int RANDOM_BYTES = 1650;
   localparam int HOLD_AFTER_ITEMS = 100;
   localparam int HOLD_CYCLES = 300;

   // Shapes of generated segments. Most are clean; the rest exercise each
   // error path and plain noise in the option area.
   typedef enum int {
      SEG_CLEAN,
      SEG_WIDE,
      SEG_LOW_OFFSET,
      SEG_SHORT,
      SEG_CUT,
      SEG_BAD_OPTION,
      SEG_NOISE,
      SEG_SHAPES
   } seg_shape_type;

   // One queued byte, with the idle cycles the sender waits before offering
   // it and whether the sender first waits for all decoded items to return.
   typedef struct {
      req_type payload;
      int      idle;
      bit      drain;
   } seg_byte_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   tcp_header_option_parser_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Stimulus: bytes waiting to be offered, and the segment being built.
   seg_byte_type segment_bytes[$];
   logic [7:0]   seg_buf[$];
   int           bytes_total = 0;
   int           segments_built = 0;

   // Decoded items the parser owes us, oldest first.
   rsp_type     items_due[$];

   // Parser state as predicted by the testbench.
   logic [15:0] seg_pos = '0;
   logic [3:0]  hdr_words = '0;
   logic [63:0] shift_acc = '0;
   int          opt_room = 0;
   logic [7:0]  opt_kind = '0;
   int          opt_len = 0;
   int          opt_idx = 0;
   bit          opt_fault = 1'b0;
   bit          opt_halted = 1'b0;
   int          step_count;

   // Handshake bookkeeping shared between the clocked processes.
   bit          req_fired = 1'b0;
   bit          rsp_fired = 1'b0;
   int          bytes_taken = 0;
   int          rsp_seen = 0;
   int          done_seen = 0;
   int          errors_seen = 0;
   int          mismatches = 0;
   int          gap_left = -1;
   int          rx_wait = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   bit          rx_eager = 1'b0;

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   task automatic post_item(input logic [4:0] kind, input logic [63:0] value,
                            input logic [2:0] err, input logic seg_end);
      rsp_type it;
      it.item_kind   = kind;
      it.item_value  = value;
      it.error_code  = err;
      it.last_of_run = 1'b0;
      it.segment_end = seg_end;
      items_due.push_back(it);
      step_count++;
   endtask

   // Advances the predicted parser by one accepted byte and queues the items
   // that byte must produce.
   task automatic decode_byte(input req_type r);
      logic [7:0] b;
      bit         ok;
      bit         body_ok;
      int         n;
      int         hdr;
      rsp_type    tail;
      b = r.data_byte;
      step_count = 0;
      shift_acc = {shift_acc[55:0], b};

      if (seg_pos < MIN_HDR_BYTES) begin
         // Fixed header: each field is reported on the byte that completes it.
         case (seg_pos)
            16'd3:  post_item(KIND_PORTS, {32'd0, shift_acc[31:0]}, ERR_NONE, 1'b0);
            16'd7:  post_item(KIND_SEQ, {32'd0, shift_acc[31:0]}, ERR_NONE, 1'b0);
            16'd11: post_item(KIND_ACK, {32'd0, shift_acc[31:0]}, ERR_NONE, 1'b0);
            16'd12: begin
               hdr_words = b[7:4];
               opt_room = (hdr_words > MIN_HDR_WORDS) ? (int'(hdr_words) - 5) * 4 : 0;
            end
            16'd13: post_item(KIND_OFFSET, {51'd0, hdr_words, shift_acc[8], b},
                              ERR_NONE, 1'b0);
            16'd15: post_item(KIND_WINDOW, {48'd0, shift_acc[15:0]}, ERR_NONE, 1'b0);
            16'd17: post_item(KIND_CHECKSUM, {48'd0, shift_acc[15:0]}, ERR_NONE, 1'b0);
            16'd19: post_item(KIND_URGENT, {48'd0, shift_acc[15:0]}, ERR_NONE, 1'b0);
            default: ;
         endcase
      end else if (!opt_halted && opt_room > 0) begin
         if (opt_idx == 0) begin
            // Kind byte. END stops the walk; NOP uses a single byte; other
            // kinds need room for at least their fixed length.
            opt_kind = b;
            if (b == OPT_END) begin
               post_item(KIND_OPT_END, 64'd0, ERR_NONE, 1'b0);
               opt_halted = 1'b1;
            end else if (b == OPT_NOP) begin
               post_item(KIND_OPT_NOP, 64'd0, ERR_NONE, 1'b0);
               opt_room--;
               if (opt_room == 0) opt_halted = 1'b1;
            end else if ((b == OPT_MSS && opt_room < 4) || (b == OPT_WSCALE && opt_room < 3) ||
                         (b == OPT_TSTAMP && opt_room < 10) || opt_room < 2) begin
               opt_fault = 1'b1;
               opt_halted = 1'b1;
            end else begin
               opt_idx = 1;
            end
         end else begin
            body_ok = 1'b1;
            if (opt_idx == 1) begin
               // Length byte, checked per kind.
               opt_len = b;
               case (opt_kind)
                  OPT_MSS:     ok = (b == 8'd4);
                  OPT_WSCALE:  ok = (b == 8'd3);
                  OPT_SACK_OK: ok = (b == 8'd2);
                  OPT_SACK:    ok = (b >= 8'd10 && b <= opt_room);
                  OPT_TSTAMP:  ok = (b == 8'd10);
                  OPT_TFO:     ok = (b >= 8'd6 && b <= 8'd18 && b <= opt_room);
                  default:     ok = (b >= 8'd2 && b <= opt_room);
               endcase
               if (!ok) begin
                  opt_fault = 1'b1;
                  opt_halted = 1'b1;
                  body_ok = 1'b0;
               end else if (opt_kind == OPT_SACK_OK) begin
                  post_item(KIND_OPT_SOK, 64'd0, ERR_NONE, 1'b0);
               end else if (opt_kind != OPT_MSS && opt_kind != OPT_WSCALE &&
                            opt_kind != OPT_SACK && opt_kind != OPT_TSTAMP &&
                            opt_kind != OPT_TFO) begin
                  post_item(KIND_OPT_UNK, {48'd0, opt_kind, b}, ERR_NONE, 1'b0);
               end
            end else begin
               // Option body. SACK reports one block per full eight bytes and
               // skips any trailing bytes.
               case (opt_kind)
                  OPT_MSS:
                     if (opt_idx == 3)
                        post_item(KIND_OPT_MSS, {48'd0, shift_acc[15:0]}, ERR_NONE, 1'b0);
                  OPT_WSCALE:
                     if (opt_idx == 2)
                        post_item(KIND_OPT_WS, {56'd0, b}, ERR_NONE, 1'b0);
                  OPT_SACK:
                     if ((opt_idx - 2) % 8 == 7 && opt_idx <= 1 + 8 * ((opt_len - 2) / 8))
                        post_item(KIND_OPT_SACK, shift_acc, ERR_NONE, 1'b0);
                  OPT_TSTAMP:
                     if (opt_idx == 9)
                        post_item(KIND_OPT_TS, shift_acc, ERR_NONE, 1'b0);
                  OPT_TFO:
                     post_item(KIND_OPT_TFO, {48'd0, 8'(opt_idx - 2), b}, ERR_NONE, 1'b0);
                  default: ;
               endcase
            end
            if (body_ok) begin
               if (opt_idx + 1 == opt_len) begin
                  opt_room = opt_room - opt_len;
                  opt_idx = 0;
                  if (opt_room == 0) opt_halted = 1'b1;
               end else begin
                  opt_idx = (opt_idx + 1) % 256;
               end
            end
         end
      end

      if (r.last_byte) begin
         // Closing item, by error priority, then back to the idle state.
         n = (seg_pos == 16'hFFFF) ? 65535 : int'(seg_pos) + 1;
         hdr = int'(hdr_words) * 4;
         if (n < MIN_HDR_BYTES)
            post_item(KIND_ERROR, 64'd0, ERR_SHORT, 1'b1);
         else if (hdr_words < MIN_HDR_WORDS)
            post_item(KIND_ERROR, 64'd0, ERR_OFFSET, 1'b1);
         else if (n < hdr)
            post_item(KIND_ERROR, 64'd0, ERR_TRUNCATED, 1'b1);
         else if (opt_fault)
            post_item(KIND_ERROR, 64'd0, ERR_OPTION, 1'b1);
         else
            post_item(KIND_DONE, 64'(n - hdr), ERR_NONE, 1'b1);
         seg_pos = '0;
         hdr_words = '0;
         shift_acc = '0;
         opt_room = 0;
         opt_kind = '0;
         opt_len = 0;
         opt_idx = 0;
         opt_fault = 1'b0;
         opt_halted = 1'b0;
      end else if (seg_pos != 16'hFFFF) begin
         seg_pos = seg_pos + 16'd1;
      end

      if (step_count > 0) begin
         tail = items_due.pop_back();
         tail.last_of_run = 1'b1;
         items_due.push_back(tail);
      end
   endtask

   // -------------------------------------------------------------------------
   // Segment construction
   // -------------------------------------------------------------------------

   task automatic put_bytes(input int count);
      int i;
      for (i = 0; i < count; i++) seg_buf.push_back(8'($urandom_range(0, 255)));
   endtask

   // Starts a new segment with a random 20-byte header carrying the given
   // data offset. Reserved bits and NS stay random.
   task automatic put_header(input logic [3:0] words);
      logic [7:0] b;
      int         i;
      seg_buf.delete();
      for (i = 0; i < 20; i++) begin
         b = 8'($urandom_range(0, 255));
         if (i == 12) b[7:4] = words;
         seg_buf.push_back(b);
      end
   endtask

   // Fills exactly room option bytes. A faulty list carries one broken option
   // somewhere, followed by random filler.
   task automatic put_options(input int room, input bit faulty);
      int left;
      int len;
      int k;
      left = room;
      while (left > 0) begin
         if (faulty && (left < 12 || $urandom_range(0, 2) == 0)) begin
            case ($urandom_range(0, 6))
               0:       k = OPT_MSS;
               1:       k = OPT_WSCALE;
               2:       k = OPT_SACK_OK;
               3:       k = OPT_SACK;
               4:       k = OPT_TSTAMP;
               5:       k = OPT_TFO;
               default: k = $urandom_range(6, 255);
            endcase
            seg_buf.push_back(8'(k));
            left--;
            if (left > 0) begin
               case ($urandom_range(0, 2))
                  0:       len = left + 1 + $urandom_range(0, 8);
                  1:       len = $urandom_range(0, 1);
                  default: len = $urandom_range(0, 255);
               endcase
               seg_buf.push_back(8'(len));
               left--;
            end
            put_bytes(left);
            left = 0;
         end else begin
            k = $urandom_range(0, 9);
            if (k == 2 && left >= 4) begin
               seg_buf.push_back(OPT_MSS);
               seg_buf.push_back(8'd4);
               put_bytes(2);
               left -= 4;
            end else if (k == 3 && left >= 3) begin
               seg_buf.push_back(OPT_WSCALE);
               seg_buf.push_back(8'd3);
               put_bytes(1);
               left -= 3;
            end else if (k == 4 && left >= 2) begin
               seg_buf.push_back(OPT_SACK_OK);
               seg_buf.push_back(8'd2);
               left -= 2;
            end else if (k == 5 && left >= 10) begin
               // Whole blocks, sometimes with trailing bytes the parser skips.
               len = 2 + 8 * $urandom_range(1, (left - 2) / 8);
               if ($urandom_range(0, 2) == 0) len += $urandom_range(0, left - len);
               seg_buf.push_back(OPT_SACK);
               seg_buf.push_back(8'(len));
               put_bytes(len - 2);
               left -= len;
            end else if (k == 6 && left >= 10) begin
               seg_buf.push_back(OPT_TSTAMP);
               seg_buf.push_back(8'd10);
               put_bytes(8);
               left -= 10;
            end else if (k == 7 && left >= 6) begin
               len = $urandom_range(6, (left < 18) ? left : 18);
               seg_buf.push_back(OPT_TFO);
               seg_buf.push_back(8'(len));
               put_bytes(len - 2);
               left -= len;
            end else if (k == 8 && left >= 2) begin
               k = $urandom_range(6, 255);
               if (k == OPT_TSTAMP || k == OPT_TFO) k++;
               len = ($urandom_range(0, 3) == 0) ? left
                                                 : $urandom_range(2, (left < 12) ? left : 12);
               seg_buf.push_back(8'(k));
               seg_buf.push_back(8'(len));
               put_bytes(len - 2);
               left -= len;
            end else if (k == 1) begin
               // END closes the list; whatever follows is ignored.
               seg_buf.push_back(OPT_END);
               left--;
               put_bytes(left);
               left = 0;
            end else begin
               seg_buf.push_back(OPT_NOP);
               left--;
            end
         end
      end
   endtask

   function automatic int random_tail_len();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 4);
   endfunction

   // Moves the built segment into the send queue, marking its final byte.
   task automatic queue_segment(input bit drain_first, input bit no_idle);
      seg_byte_type s;
      int           i;
      for (i = 0; i < seg_buf.size(); i++) begin
         s.payload.data_byte = seg_buf[i];
         s.payload.last_byte = (i == seg_buf.size() - 1);
         s.idle = no_idle ? 0 : $urandom_range(0, 4);
         s.drain = drain_first && (i == 0);
         segment_bytes.push_back(s);
      end
      bytes_total += seg_buf.size();
      segments_built++;
   endtask

   // -------------------------------------------------------------------------
   // Sender: offers queued bytes at the falling edge. A byte stays on the bus
   // until it is taken; the next one goes out only after its own idle count.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin : sender
      seg_byte_type head;
      bit           offer;
      if (!reset && (!req_valid || req_fired)) begin
         req_fired = 1'b0;
         offer = 1'b0;
         if (segment_bytes.size() != 0) begin
            if (gap_left < 0) gap_left = segment_bytes[0].idle;
            if (gap_left > 0) begin
               gap_left--;
            end else if (!segment_bytes[0].drain || items_due.size() == 0) begin
               head = segment_bytes.pop_front();
               offer = 1'b1;
               gap_left = -1;
            end
         end
         req_valid <= offer;
         if (offer) req_data <= head.payload;
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: random ready gaps after each item, stretches of eager accepts,
   // and one long hold-off that backs the parser up into its input.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin : receiver
      if (!reset) begin
         if (rsp_fired) begin
            rsp_fired = 1'b0;
            if (rsp_seen % 50 == 0) rx_eager = ($urandom_range(0, 3) == 0);
            rx_wait = rx_eager ? 0 : $urandom_range(0, 4);
         end
         if (!hold_done && rsp_seen >= HOLD_AFTER_ITEMS) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rx_wait > 0) begin
            rx_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: at the rising edge, predicts items for each byte taken and
   // checks each item delivered against the oldest prediction.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (req_valid && req_ready) begin
         decode_byte(req_data);
         req_fired = 1'b1;
         bytes_taken++;
      end
      if (rsp_valid && rsp_ready) begin
         rsp_seen++;
         rsp_fired = 1'b1;
         if (rsp_data.segment_end) begin
            if (rsp_data.item_kind == KIND_DONE) done_seen++;
            else errors_seen++;
         end
         if (items_due.size() == 0) begin
            if (mismatches < 10)
               $display("Unexpected item %0d: kind %0d value %h code %0d",
                        rsp_seen, rsp_data.item_kind, rsp_data.item_value,
                        rsp_data.error_code);
            mismatches++;
         end else begin
            want = items_due.pop_front();
            if (rsp_data.item_kind !== want.item_kind ||
                rsp_data.item_value !== want.item_value ||
                rsp_data.error_code !== want.error_code ||
                rsp_data.last_of_run !== want.last_of_run ||
                rsp_data.segment_end !== want.segment_end) begin
               if (mismatches < 10) begin
                  $display("Mismatch on item %0d:", rsp_seen);
                  $display("  expected kind %0d value %h code %0d last %0b end %0b",
                           want.item_kind, want.item_value, want.error_code,
                           want.last_of_run, want.segment_end);
                  $display("  actual   kind %0d value %h code %0d last %0b end %0b",
                           rsp_data.item_kind, rsp_data.item_value, rsp_data.error_code,
                           rsp_data.last_of_run, rsp_data.segment_end);
               end
               mismatches++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence: build every segment up front, release reset, then wait
   // for all bytes to be taken and all items to come back.
   // -------------------------------------------------------------------------
   initial begin : main
      int            i;
      int            roll;
      int            words;
      int            keep;
      int            random_bytes;
      seg_shape_type shape;

      // Directed: a lone zero byte (too short), then an all-ones header with
      // offset 6 whose MSS option completes on the final byte, so that byte
      // yields two items.
      seg_buf.delete();
      seg_buf.push_back(8'h00);
      queue_segment(1'b0, 1'b0);
      put_header(4'd6);
      for (i = 0; i < 20; i++) seg_buf[i] = (i == 12) ? 8'h6F : 8'hFF;
      seg_buf.push_back(OPT_MSS);
      seg_buf.push_back(8'd4);
      seg_buf.push_back(8'hFF);
      seg_buf.push_back(8'hFF);
      queue_segment(1'b0, 1'b0);

      // Random segments: the first two passes walk every shape in turn, then
      // clean segments dominate. Now and then the sender drains first.
      random_bytes = 0;
      while (random_bytes < RANDOM_BYTES) begin
         if (segments_built < 2 + 2 * SEG_SHAPES) begin
            shape = seg_shape_type'(segments_built % SEG_SHAPES);
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 45)      shape = SEG_CLEAN;
            else if (roll < 55) shape = SEG_WIDE;
            else if (roll < 63) shape = SEG_LOW_OFFSET;
            else if (roll < 71) shape = SEG_SHORT;
            else if (roll < 79) shape = SEG_CUT;
            else if (roll < 91) shape = SEG_BAD_OPTION;
            else                shape = SEG_NOISE;
         end
         words = $urandom_range(6, 15);
         case (shape)
            SEG_CLEAN: begin
               words = $urandom_range(5, 15);
               put_header(4'(words));
               put_options((words - 5) * 4, 1'b0);
               put_bytes(random_tail_len());
            end
            SEG_WIDE: begin
               put_header(4'd15);
               put_options(40, 1'b0);
               put_bytes(random_tail_len());
            end
            SEG_LOW_OFFSET: begin
               put_header(4'($urandom_range(0, 4)));
               put_bytes($urandom_range(0, 12));
            end
            SEG_SHORT: begin
               put_header(4'($urandom_range(0, 15)));
               keep = $urandom_range(1, 19);
               while (seg_buf.size() > keep) void'(seg_buf.pop_back());
            end
            SEG_CUT: begin
               put_header(4'(words));
               put_options((words - 5) * 4, 1'b0);
               keep = $urandom_range(20, words * 4 - 1);
               while (seg_buf.size() > keep) void'(seg_buf.pop_back());
            end
            SEG_BAD_OPTION: begin
               put_header(4'(words));
               put_options((words - 5) * 4, 1'b1);
               put_bytes(random_tail_len());
            end
            default: begin
               put_header(4'(words));
               put_bytes((words - 5) * 4);
               put_bytes(random_tail_len());
            end
         endcase
         random_bytes += seg_buf.size();
         queue_segment(segments_built % 25 == 10, $urandom_range(0, 4) == 0);
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (bytes_taken == bytes_total);
      while (items_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d segments (%0d bytes) of every shape and checked %0d items:",
               segments_built, bytes_total, rsp_seen);
      $display("  %0d segments closed with a payload length, %0d with an error; %0d mismatches.",
               done_seen, errors_seen, mismatches);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin : watchdog
      #(20_000_000);
      $display("Timeout with %0d of %0d bytes taken and %0d items outstanding",
               bytes_taken, bytes_total, items_due.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
